FILE: rtl/rc5_pkg.sv
`default_nettype none

package rc5_pkg;

  // Default round count and fixed cipher dimensions.
  localparam int unsigned DEF_ROUNDS = 12;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ROT_W      = 5;
  localparam int unsigned KEY_IDX_W  = 2;

  // Magic constants of the key schedule.
  localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E1_5163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E37_79B9;

  // Shift amount of the round-key half of a mix step.
  localparam logic [ROT_W-1:0] SCHED_ROT = 5'd3;

  // Action codes carried by an input beat.
  typedef enum logic [1:0] {
    ACT_EXPAND  = 2'd0,
    ACT_ENCRYPT = 2'd1,
    ACT_DECRYPT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_A,
    ST_EXP_B,
    ST_CIPH,
    ST_DONE
  } state_t;

  // Rotate left; an amount of zero returns the input.
  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                               input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] t;
    t = {v, v} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  // Rotate right; an amount of zero returns the input.
  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] v,
                                               input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] t;
    t = {v, v} >> n;
    return t[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rc5_ram.sv
`default_nettype none

module rc5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/rc5_block_cipher_unit.sv
`default_nettype none

// RC5-32 block cipher with a 16-byte key held in four key registers. An expand
// beat builds the table of 2*(ROUNDS+1) round keys from the current key
// registers; encrypt and decrypt beats then transform one 64-bit block given as
// two words. A small sequencer drives the adders and rotators, so one beat is
// in flight at a time. Expansion runs 6*(ROUNDS+1) schedule steps, each in
// two states: ST_EXP_A updates A and a table entry, ST_EXP_B updates B and
// L. Encrypt and decrypt walk all 2*(ROUNDS+1) round keys in turn, one
// round-key read from the key table per cycle, then hand the result to the
// output register. The output register lets the next beat be taken while a
// result waits. Encrypt or decrypt before the first expand returns zero
// words with key_not_ready set; an expand or the unused action code returns
// all zeros.
module rc5_block_cipher_unit #(
  parameter int unsigned ROUNDS = rc5_pkg::DEF_ROUNDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [rc5_pkg::KEY_IDX_W-1:0] cfg_index,
  input  wire logic [rc5_pkg::WORD_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  action,
  input  wire logic [rc5_pkg::WORD_W-1:0]  left_word,
  input  wire logic [rc5_pkg::WORD_W-1:0]  right_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [rc5_pkg::WORD_W-1:0]  left_result,
  output logic      [rc5_pkg::WORD_W-1:0]  right_result,
  output logic                             key_not_ready
);

  import rc5_pkg::*;

  localparam int unsigned TABLE = 2 * (ROUNDS + 1);
  localparam int unsigned IW    = $clog2(TABLE);
  localparam int unsigned MIX   = 3 * TABLE;
  localparam int unsigned KW    = $clog2(MIX);
  localparam logic [IW-1:0] IDX_LAST = IW'(TABLE - 1);
  localparam logic [KW-1:0] K_LAST   = KW'(MIX - 1);
  localparam logic [KW-1:0] K_PASS   = KW'(TABLE);

  // Control and working registers.
  state_t state, state_next;
  logic [WORD_W-1:0] a, a_next, b, b_next;
  logic nr, nr_next;
  logic dir, dir_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] i, i_next;
  logic [KEY_IDX_W-1:0] j, j_next;
  logic [KW-1:0] k, k_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic keys_valid, keys_valid_next;
  logic [WORD_W-1:0] key [KEY_WORDS];
  logic [WORD_W-1:0] l [KEY_WORDS];
  logic [WORD_W-1:0] l_wdata;
  logic l_we;
  logic out_load;

  // Key table memory ports.
  logic ram_we;
  logic [IW-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Shared datapath signals.
  logic [WORD_W-1:0] cx, cy, enc_t, enc_r, dec_d, dec_r, unit_r;
  logic whiten;
  logic [WORD_W-1:0] s_val, mix_a, ab, mix_b;
  logic [IW-1:0] i_inc;
  logic [IW-1:0] idx_step;
  logic [IW-1:0] idx_end;

  rc5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (i),
    .wdata (mix_a),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cipher half-round: the word in play is chosen by the key-table parity.
  assign cx     = idx[0] ? b : a;
  assign cy     = idx[0] ? a : b;
  assign whiten = (idx >> 1) == '0;
  assign enc_t  = whiten ? cx : rotl32(cx ^ cy, cy[ROT_W-1:0]);
  assign enc_r  = enc_t + ram_rdata;
  assign dec_d  = cx - ram_rdata;
  assign dec_r  = whiten ? dec_d : (rotr32(dec_d, cy[ROT_W-1:0]) ^ cy);
  assign unit_r = dir ? dec_r : enc_r;
  assign idx_step = dir ? (idx - 1'b1) : (idx + 1'b1);
  assign idx_end  = dir ? '0 : IDX_LAST;

  // Key schedule: the first pass reads the initial table from the accumulator.
  assign s_val = (k < K_PASS) ? acc : ram_rdata;
  assign mix_a = rotl32(s_val + a + b, SCHED_ROT);
  assign ab    = a + b;
  assign mix_b = rotl32(l[j] + ab, ab[ROT_W-1:0]);
  assign i_inc = (i == IDX_LAST) ? '0 : (i + 1'b1);

  assign in_ready = (state == ST_IDLE);

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_next      = state;
    a_next          = a;
    b_next          = b;
    nr_next         = nr;
    dir_next        = dir;
    idx_next        = idx;
    i_next          = i;
    j_next          = j;
    k_next          = k;
    acc_next        = acc;
    keys_valid_next = keys_valid;
    ram_we          = 1'b0;
    ram_raddr       = idx;
    l_we            = 1'b0;
    l_wdata         = mix_b;
    out_load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (action_t'(action))
            ACT_EXPAND: begin
              a_next     = '0;
              b_next     = '0;
              nr_next    = 1'b0;
              i_next     = '0;
              j_next     = '0;
              k_next     = '0;
              acc_next   = MAGIC_P;
              state_next = ST_EXP_A;
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
              if (keys_valid) begin
                a_next     = left_word;
                b_next     = right_word;
                nr_next    = 1'b0;
                dir_next   = (action_t'(action) == ACT_DECRYPT);
                idx_next   = (action_t'(action) == ACT_DECRYPT) ? IDX_LAST : '0;
                ram_raddr  = idx_next;
                state_next = ST_CIPH;
              end else begin
                a_next     = '0;
                b_next     = '0;
                nr_next    = 1'b1;
                state_next = ST_DONE;
              end
            end
            default: begin
              a_next     = '0;
              b_next     = '0;
              nr_next    = 1'b0;
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_EXP_A: begin
        ram_we     = 1'b1;
        a_next     = mix_a;
        state_next = ST_EXP_B;
      end
      ST_EXP_B: begin
        b_next    = mix_b;
        l_we      = 1'b1;
        acc_next  = acc + MAGIC_Q;
        i_next    = i_inc;
        j_next    = j + 1'b1;
        ram_raddr = i_inc;
        if (k == K_LAST) begin
          keys_valid_next = 1'b1;
          a_next          = '0;
          b_next          = '0;
          state_next      = ST_DONE;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_EXP_A;
        end
      end
      ST_CIPH: begin
        if (idx[0]) begin
          b_next = unit_r;
        end else begin
          a_next = unit_r;
        end
        if (idx == idx_end) begin
          state_next = ST_DONE;
        end else begin
          idx_next  = idx_step;
          ram_raddr = idx_step;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      keys_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int n = 0; n < KEY_WORDS; n++) begin
        key[n] <= '0;
      end
    end else begin
      state      <= state_next;
      keys_valid <= keys_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        key[cfg_index] <= cfg_data;
      end
    end
  end

  // Datapath registers and the output register.
  always_ff @(posedge clk) begin
    a   <= a_next;
    b   <= b_next;
    nr  <= nr_next;
    dir <= dir_next;
    idx <= idx_next;
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    acc <= acc_next;
    if (state == ST_IDLE && in_valid && action_t'(action) == ACT_EXPAND) begin
      for (int n = 0; n < KEY_WORDS; n++) begin
        l[n] <= key[n];
      end
    end else if (l_we) begin
      l[j] <= l_wdata;
    end
    if (out_load) begin
      left_result   <= a;
      right_result  <= b;
      key_not_ready <= nr;
    end
  end

endmodule

`default_nettype wire
